// ----- rtl/assert_macros.svh -----
// Assertion macros for the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication that must hold at every clock edge out of reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Condition that must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

`endif

// ----- rtl/stq_pkg.sv -----
// ----------------------------------------------------------------------------
// stq_pkg
// Types and codes shared by the timer queue files.
// ----------------------------------------------------------------------------
package stq_pkg;

    typedef enum logic [1:0] {
        FUNC_ATTACH = 2'd0,
        FUNC_DETACH = 2'd1,
        FUNC_TICK   = 2'd2,
        FUNC_REARM  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_ATTACHED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EXPIRED  = 2'd2
    } status_t;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] now_ms;
        logic [3:0]  slot;
        logic [15:0] timer_id;
        logic [15:0] wait_ms;
        logic        stop;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  out_slot;
        logic [15:0] out_id;
        logic [15:0] call_count;
        logic        last_of_run;
    } out_item_t;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD,
        ST_INS_RD,
        ST_INS_CMP,
        ST_INS_LINK,
        ST_DET_RD,
        ST_DET_CMP,
        ST_TICK_RD,
        ST_TICK_CMP,
        ST_EMIT_RD,
        ST_EMIT,
        ST_WAIT_OUT
    } state_t;

endpackage

// ----- rtl/stq_if.sv -----
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if
// Valid/ready channels carrying one input item or one result item per beat.
// ----------------------------------------------------------------------------
interface stq_in_if;
    import stq_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stq_out_if;
    import stq_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/stq_ram.sv -----
// ----------------------------------------------------------------------------
// stq_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/sorted_timer_queue.sv -----
// An attach to a full pool reports at once without a list walk; other attaches and
// rearms walk the armed list to the insert point, a detach walks it to its slot, and a
// tick examines slots from the head, then emits one result per expired slot.
// One item is processed at a time; the rate is set by the walk of the linked
// list through the slot memory with its registered read, one slot after another.
// Reset (async, active low) forms the free list 0..SLOTS-1 and empties the
// armed list; the link table has per-slot reset through the next-pointer regs.
// ----------------------------------------------------------------------------
// sorted_timer_queue
// Timer pool with a free list and a deadline-sorted armed list in memory.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sorted_timer_queue #(
    parameter int SLOTS = 16
) (
    input logic       clk,
    input logic       rst_n,
    stq_in_if.sink    in_ch,
    stq_out_if.source out_ch
);
    import stq_pkg::*;

    localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(SLOTS);
    localparam int DW = 16 + 16 + 32 + 16;
    localparam int CW = $clog2(SLOTS + 1);

    // Slot data memory: ident, interval, start, calls.
    logic          dm_we;
    logic [AW-1:0] dm_waddr, dm_raddr;
    logic [DW-1:0] dm_wdata, dm_rdata;
    stq_ram #(.WIDTH(DW), .DEPTH(SLOTS)) u_data (
        .clk(clk), .we(dm_we), .waddr(dm_waddr), .wdata(dm_wdata),
        .raddr(dm_raddr), .rdata(dm_rdata)
    );

    // Link table: small, reset-initialized, kept in registers with up to
    // two writes per cycle to different slots.
    logic [LW-1:0] link_reg [SLOTS];
    logic          lk_we;
    logic [AW-1:0] lk_waddr;
    logic [LW-1:0] lk_wdata;
    logic          lk2_we;
    logic [AW-1:0] lk2_waddr;
    logic [LW-1:0] lk2_wdata;
    logic [SLOTS-1:0] pend_reg;
    logic [SLOTS-1:0] pend_set, pend_clr;
    // Popped-slot stack for tick reporting, latest first.
    logic [AW-1:0] pop_reg [SLOTS];
    logic          pop_we;

    state_t        state_reg, state_next;
    in_item_t      it_reg, it_next;
    logic [LW-1:0] armed_head_reg, armed_head_next;
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] s_reg, s_next;
    logic [31:0]   sdl_reg, sdl_next;   // start of inserted slot
    logic [15:0]   siv_reg, siv_next;   // interval of inserted slot
    logic          ov_reg, ov_next;
    out_item_t     od_reg, od_next;

    logic [15:0] r_id, r_iv, r_calls;
    logic [31:0] r_st, r_d, r_dd;
    logic [AW-1:0] cur_a;
    logic          out_free;

    assign {r_id, r_iv, r_st, r_calls} = dm_rdata;
    assign cur_a   = cur_reg[AW-1:0];
    assign out_free = !ov_reg || out_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) && out_free;
    assign out_ch.valid = ov_reg;
    assign out_ch.data  = od_reg;
    assign r_d  = it_reg.now_ms - r_st;
    assign r_dd = r_d[31] ? (r_st - it_reg.now_ms) : r_d;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                unique case (func_t'(it_reg.func))
                    FUNC_ATTACH:
                        state_next = (free_head_reg >= NIL) ? ST_WAIT_OUT : ST_INS_RD;
                    FUNC_DETACH:
                        state_next = (32'(it_reg.slot) >= SLOTS) ? ST_IDLE : ST_DET_RD;
                    FUNC_TICK:   state_next = ST_TICK_RD;
                    FUNC_REARM:
                        state_next = (32'(it_reg.slot) >= SLOTS
                                      || !pend_reg[it_reg.slot[AW-1:0]]
                                      || it_reg.stop) ? ST_IDLE : ST_INS_RD;
                    default:     state_next = ST_IDLE;
                endcase
            end
            ST_INS_RD:   state_next = (cur_reg >= NIL || 32'(cnt_reg) >= SLOTS)
                                      ? ST_INS_LINK : ST_INS_CMP;
            ST_INS_CMP:
                state_next = ((r_st + 32'(r_iv) - sdl_reg) < 32'(siv_reg))
                             ? ST_INS_RD : ST_INS_LINK;
            ST_INS_LINK: state_next = (it_reg.func == FUNC_ATTACH) ? ST_WAIT_OUT : ST_IDLE;
            ST_DET_RD:
                state_next = (cur_reg >= NIL || 32'(cnt_reg) >= SLOTS) ? ST_IDLE
                             : (cur_a == s_reg) ? ST_IDLE : ST_DET_CMP;
            ST_DET_CMP:  state_next = ST_DET_RD;
            ST_TICK_RD:
                state_next = (armed_head_reg >= NIL || 32'(cnt_reg) >= SLOTS)
                             ? ((cnt_reg == '0) ? ST_IDLE : ST_EMIT_RD) : ST_TICK_CMP;
            ST_TICK_CMP:
                state_next = (r_dd < 32'(r_iv))
                             ? ((cnt_reg == '0) ? ST_IDLE : ST_EMIT_RD) : ST_TICK_RD;
            ST_EMIT_RD:  state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = (cnt_reg == CW'(1)) ? ST_IDLE : ST_EMIT_RD;
                end
            end
            ST_WAIT_OUT: if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb
    begin
        it_next = it_reg;
        armed_head_next = armed_head_reg;
        free_head_next = free_head_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        cnt_next = cnt_reg;
        s_next = s_reg;
        sdl_next = sdl_reg;
        siv_next = siv_reg;
        ov_next = ov_reg && !out_ch.ready;
        od_next = od_reg;
        dm_we = 1'b0;
        dm_waddr = s_reg;
        dm_wdata = '0;
        dm_raddr = cur_a;
        lk_we = 1'b0;
        lk_waddr = s_reg;
        lk_wdata = NIL;
        lk2_we = 1'b0;
        lk2_waddr = prev_reg[AW-1:0];
        lk2_wdata = LW'(s_reg);
        pend_set = '0;
        pend_clr = '0;
        pop_we = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    it_next = in_ch.data;
                    s_next = in_ch.data.slot[AW-1:0];
                end
                dm_raddr = in_ch.data.slot[AW-1:0];
            end
            ST_RD:
            begin
                // Data of the addressed slot is now on the read port.
                cnt_next = '0;
                prev_next = NIL;
                cur_next = armed_head_reg;
                unique case (func_t'(it_reg.func))
                    FUNC_ATTACH:
                    begin
                        if (free_head_reg >= NIL)
                        begin
                            od_next = '{STAT_FULL, 4'd0, 16'd0, 16'd0, 1'b1};
                        end
                        else
                        begin
                            s_next = free_head_reg[AW-1:0];
                            free_head_next = link_reg[free_head_reg[AW-1:0]];
                            sdl_next = it_reg.now_ms;
                            siv_next = it_reg.wait_ms;
                            dm_we = 1'b1;
                            dm_waddr = free_head_reg[AW-1:0];
                            dm_wdata = {it_reg.timer_id, it_reg.wait_ms,
                                        it_reg.now_ms, 16'd0};
                            od_next = '{STAT_ATTACHED, 4'(free_head_reg),
                                        16'd0, 16'd0, 1'b1};
                        end
                    end
                    FUNC_REARM:
                    begin
                        if (32'(it_reg.slot) < SLOTS && pend_reg[s_reg])
                        begin
                            pend_clr[s_reg] = 1'b1;
                            if (it_reg.stop)
                            begin
                                lk_we = 1'b1;
                                lk_wdata = free_head_reg;
                                free_head_next = LW'(s_reg);
                            end
                            else
                            begin
                                sdl_next = r_st + 32'(r_iv);
                                siv_next = it_reg.wait_ms;
                                dm_we = 1'b1;
                                dm_wdata = {r_id, it_reg.wait_ms,
                                            r_st + 32'(r_iv), r_calls + 16'd1};
                            end
                        end
                    end
                    default: ;
                endcase
            end
            ST_INS_CMP:
            begin
                if ((r_st + 32'(r_iv) - sdl_reg) < 32'(siv_reg))
                begin
                    prev_next = cur_reg;
                    cur_next = link_reg[cur_a];
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_INS_LINK:
            begin
                // The new slot points to its successor, and its predecessor
                // (or the head) points to the new slot.
                if (prev_reg >= NIL)
                begin
                    armed_head_next = LW'(s_reg);
                end
                else
                begin
                    lk2_we = 1'b1;
                    lk2_wdata = LW'(s_reg);
                end
                lk_we = 1'b1;
                lk_wdata = (cur_reg < NIL) ? cur_reg : NIL;
            end
            ST_DET_RD:
            begin
                if (!(cur_reg >= NIL || 32'(cnt_reg) >= SLOTS) && cur_a == s_reg)
                begin
                    if (prev_reg >= NIL)
                    begin
                        armed_head_next = link_reg[cur_a];
                    end
                    else
                    begin
                        lk2_we = 1'b1;
                        lk2_wdata = link_reg[cur_a];
                    end
                    lk_we = 1'b1;
                    lk_wdata = free_head_reg;
                    free_head_next = cur_reg;
                end
            end
            ST_DET_CMP:
            begin
                prev_next = cur_reg;
                cur_next = link_reg[cur_a];
                cnt_next = cnt_reg + CW'(1);
            end
            ST_TICK_RD:
            begin
                dm_raddr = armed_head_reg[AW-1:0];
            end
            ST_TICK_CMP:
            begin
                if (!(r_dd < 32'(r_iv)))
                begin
                    armed_head_next = link_reg[armed_head_reg[AW-1:0]];
                    lk_we = 1'b1;
                    lk_waddr = armed_head_reg[AW-1:0];
                    lk_wdata = NIL;
                    pend_set[armed_head_reg[AW-1:0]] = 1'b1;
                    pop_we = 1'b1;
                    cnt_next = cnt_reg + CW'(1);
                end
            end
            ST_EMIT_RD:
            begin
                dm_raddr = pop_reg[cnt_reg[AW-1:0] - AW'(1)];
            end
            ST_EMIT:
            begin
                // Keep the same slot on the read port while the result waits.
                dm_raddr = pop_reg[cnt_reg[AW-1:0] - AW'(1)];
                if (out_free)
                begin
                    od_next = '{STAT_EXPIRED,
                                4'(pop_reg[cnt_reg[AW-1:0] - AW'(1)]),
                                r_id, r_calls, cnt_reg == CW'(1)};
                    ov_next = 1'b1;
                    cnt_next = cnt_reg - CW'(1);
                end
            end
            ST_WAIT_OUT:
            begin
                if (out_free)
                begin
                    ov_next = 1'b1;
                end
            end
            default: ;
        endcase
        // Pointer walk for the insert and detach loops.
        if (state_reg == ST_INS_RD || state_reg == ST_DET_RD)
        begin
            dm_raddr = cur_a;
        end
    end

    // Registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            armed_head_reg <= NIL;
            free_head_reg <= '0;
            ov_reg <= 1'b0;
            pend_reg <= '0;
            cnt_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                link_reg[i] <= LW'(i + 1);
            end
        end
        else
        begin
            state_reg <= state_next;
            armed_head_reg <= armed_head_next;
            free_head_reg <= free_head_next;
            ov_reg <= ov_next;
            pend_reg <= (pend_reg | pend_set) & ~pend_clr;
            cnt_reg <= cnt_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (lk_we && lk_waddr == AW'(i))
                begin
                    link_reg[i] <= lk_wdata;
                end
                else if (lk2_we && lk2_waddr == AW'(i))
                begin
                    link_reg[i] <= lk2_wdata;
                end
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        it_reg <= it_next;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        s_reg <= s_next;
        sdl_reg <= sdl_next;
        siv_reg <= siv_next;
        od_reg <= od_next;
        if (pop_we)
        begin
            pop_reg[cnt_reg[AW-1:0]] <= armed_head_reg[AW-1:0];
        end
    end

    // Checks.
    `ASSERT_IMPL(a_ready_idle, clk, rst_n, in_ch.ready, state_reg == ST_IDLE)
    `ASSERT_IMPL(a_hold_out, clk, rst_n, out_ch.valid && !out_ch.ready,
                 ##1 out_ch.valid && $stable(out_ch.data))
    `ASSERT_ALWAYS(a_heads, clk, rst_n, armed_head_reg <= NIL && free_head_reg <= NIL)
endmodule
